### sv/dct_pkg.sv
// ----------------------------------------------------------------------------
// dct_pkg
// Shared types and constants for the trial-division divisor counter.
// ----------------------------------------------------------------------------
package dct_pkg;

    // Result and target widths
    localparam int COUNT_W  = 8;
    localparam int TARGET_W = 8;

    localparam logic [TARGET_W-1:0] TARGET_RESET = 8'd18;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = 8'd255;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture a new value, restart the trial sequence
        logic start_div;  // launch one remainder computation
        logic step;       // fold the remainder into the count, advance divisor
        logic publish;    // move the final count into the output register
    } dct_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic more_trials;  // divisor squared still within the value
        logic div_done;     // remainder ready
        logic out_free;     // output register can take a result this cycle
    } dct_status_t;

endpackage

### sv/dct_value_if.sv
// ----------------------------------------------------------------------------
// dct_value_if
// Valid/ready channel carrying one value beat.
// ----------------------------------------------------------------------------
interface dct_value_if #(
    parameter int VALUE_BITS = 20
) ();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

### sv/dct_result_if.sv
// ----------------------------------------------------------------------------
// dct_result_if
// Valid/ready channel carrying one divisor count result beat.
// ----------------------------------------------------------------------------
interface dct_result_if import dct_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] divisor_count;
    logic               count_matches;

    modport source (output valid, output divisor_count, output count_matches, input ready);
    modport sink   (input valid, input divisor_count, input count_matches, output ready);
endinterface

### sv/dct_rem_unit.sv
// ----------------------------------------------------------------------------
// dct_rem_unit
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module dct_rem_unit import dct_pkg::*; #(
    parameter int VALUE_BITS = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [VALUE_BITS-1:0] divisor,
    output logic                  done,
    output logic                  rem_zero
);
    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] dvd_reg, dvd_next;
    logic [VALUE_BITS-1:0] div_reg, div_next;
    logic [VALUE_BITS:0]   shifted;
    logic [VALUE_BITS:0]   diff;

    // One restoring step
    assign shifted = {rem_reg, dvd_reg[VALUE_BITS-1]};
    assign diff    = shifted - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VALUE_BITS);
            rem_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            // keep the shifted value unless the divisor fits
            if (diff[VALUE_BITS])
                rem_next = shifted[VALUE_BITS-1:0];
            else
                rem_next = diff[VALUE_BITS-1:0];
            dvd_next = {dvd_reg[VALUE_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign rem_zero = (rem_reg == '0);

    // Partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg || done_reg) |-> (rem_reg < div_reg))
        else $error("remainder not below divisor");

    // A start always leads into a busy pass
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("remainder unit did not start");

endmodule

### sv/dct_datapath.sv
// ----------------------------------------------------------------------------
// dct_datapath
// Value, trial divisor, running square, count and the output register.
// ----------------------------------------------------------------------------
module dct_datapath import dct_pkg::*; #(
    parameter int VALUE_BITS = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dct_cmd_t              cmd,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [TARGET_W-1:0]   target_count,
    input  logic                  out_ready,
    output dct_status_t           status,
    output logic                  out_valid,
    output logic [COUNT_W-1:0]    divisor_count,
    output logic                  count_matches
);
    // square of the trial divisor never exceeds value + 2*sqrt(value) + 1
    localparam int SQ_W = VALUE_BITS + 2;

    logic [VALUE_BITS-1:0] held_reg;
    logic [VALUE_BITS-1:0] trial_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic                  out_valid_reg;
    logic [COUNT_W-1:0]    out_count_reg;
    logic                  out_match_reg;
    logic                  rem_zero;
    logic                  div_done;
    logic [COUNT_W:0]      count_sum;
    logic                  is_root;

    dct_rem_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .dividend (held_reg),
        .divisor  (trial_reg),
        .done     (div_done),
        .rem_zero (rem_zero)
    );

    // Divisor pair adds two, a square root adds one; saturate the count
    assign is_root   = (sq_reg == {2'b00, held_reg});
    assign count_sum = {1'b0, count_reg} + (is_root ? (COUNT_W+1)'(1) : (COUNT_W+1)'(2));

    always_comb
    begin
        count_next = count_reg;
        if (cmd.load)
            count_next = '0;
        else if (cmd.step && rem_zero)
            count_next = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];
    end

    // Trial sequence registers; (d+1)^2 = d^2 + 2d + 1
    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        if (cmd.load)
        begin
            held_reg  <= value;
            trial_reg <= VALUE_BITS'(1);
            sq_reg    <= SQ_W'(1);
        end
        else if (cmd.step)
        begin
            trial_reg <= trial_reg + 1'b1;
            sq_reg    <= sq_reg + {1'b0, trial_reg, 1'b1};
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.publish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_count_reg <= count_reg;
            out_match_reg <= (count_reg == target_count);
        end
    end

    assign status.more_trials = (sq_reg <= {2'b00, held_reg});
    assign status.div_done    = div_done;
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign divisor_count = out_count_reg;
    assign count_matches = out_match_reg;

endmodule

### sv/dct_ctrl.sv
// ----------------------------------------------------------------------------
// dct_ctrl
// Sequencer: check the next trial, run a remainder, fold it in, publish.
// ----------------------------------------------------------------------------
module dct_ctrl import dct_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  dct_status_t status,
    output dct_cmd_t    cmd
);
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   accepted;

    assign in_ready = (state_reg == ST_IDLE);
    assign accepted = in_valid && in_ready;

    // Next state and command decode
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.more_trials)
                begin
                    cmd.start_div = 1'b1;
                    state_next    = ST_DIVIDE;
                end
                else
                    state_next = ST_FINISH;
            end
            ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // A result is only published into a free output register
    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> status.out_free)
        else $error("publish into occupied output register");

    // An accepted beat always starts a trial sequence
    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        accepted |=> (state_reg == ST_CHECK))
        else $error("accepted beat did not start trials");

endmodule

### sv/divisor_count_trial_division_top.sv
// ----------------------------------------------------------------------------
// divisor_count_trial_division_top
// Operation: each trial divisor takes one check state, then a pass through
//   the bit-serial remainder unit, and trials run while d*d <= value.
// Flow: a new value is taken only once the last one is published; a finished
//   result waits in the output register while the next value is taken.
// Reset: rst_n clears control state and sets the target count to 18.
// ----------------------------------------------------------------------------
module divisor_count_trial_division_top import dct_pkg::*; #(
    parameter int VALUE_BITS = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    dct_value_if.sink             in_ch,
    dct_result_if.source          out_ch,
    input  logic                  cfg_wr_en,
    input  logic [TARGET_W-1:0]   cfg_wr_data
);
    logic [TARGET_W-1:0] target_reg;
    dct_cmd_t            cmd;
    dct_status_t         status;
    logic                in_ready;

    // Target count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            target_reg <= TARGET_RESET;
        else if (cfg_wr_en)
            target_reg <= cfg_wr_data;
    end

    dct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dct_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .value         (in_ch.value),
        .target_count  (target_reg),
        .out_ready     (out_ch.ready),
        .status        (status),
        .out_valid     (out_ch.valid),
        .divisor_count (out_ch.divisor_count),
        .count_matches (out_ch.count_matches)
    );

    assign in_ch.ready = in_ready;

endmodule

### sim/dct_count_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_count_monitor
// Watches the value, result and target-write ports of the divisor counter.
// Every accepted value beat is turned into an expected divisor count and match
// flag. Every accepted result beat is compared against the oldest one.
// ----------------------------------------------------------------------------
module dct_count_monitor import dct_pkg::*; #(
    parameter int VALUE_BITS = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  value_valid,
    input  logic                  value_ready,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  logic [COUNT_W-1:0]    divisor_count,
    input  logic                  count_matches,
    input  logic                  cfg_wr_en,
    input  logic [TARGET_W-1:0]   cfg_wr_data,
    output int                    pending,
    output int                    fail_count
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               hit;
    } count_expect_t;

    count_expect_t       count_fifo [$];
    count_expect_t       head;
    count_expect_t       fresh;
    logic [TARGET_W-1:0] target;

    // Divisor count by pairs (d, v/d) with d*d <= v, saturated to the count width
    function automatic logic [COUNT_W-1:0] tally_divisors(input logic [VALUE_BITS-1:0] v);
        longint unsigned n;
        longint unsigned d;
        longint unsigned total;
        n = 64'(v);
        total = 0;
        for (d = 1; d * d <= n; d++)
        begin
            if (n % d == 0)
                total += (d * d == n) ? 64'd1 : 64'd2;
        end
        if (total > COUNT_MAX)
            total = 64'(COUNT_MAX);
        return total[COUNT_W-1:0];
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
        target     = TARGET_RESET;
    end

    // Result compare first, then target update, then new expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_fifo.delete();
            target  = TARGET_RESET;
            pending = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (count_fifo.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected result: count %0d match %0b",
                                 $realtime, divisor_count, count_matches);
                end
                else
                begin
                    head = count_fifo.pop_front();
                    if (divisor_count !== head.count || count_matches !== head.hit)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: mismatch: exp %0d/%0b got %0d/%0b",
                                     $realtime, head.count, head.hit,
                                     divisor_count, count_matches);
                    end
                end
            end

            if (cfg_wr_en)
                target = cfg_wr_data;

            if (value_valid && value_ready)
            begin
                fresh.count = tally_divisors(value);
                fresh.hit   = (fresh.count == target);
                count_fifo.push_back(fresh);
            end

            pending = count_fifo.size();
        end
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the trial-division divisor counter. Drives landmark values
// (zero, one, primes, squares, powers of two, highly composite numbers, the
// all-ones value) and then random values, mostly small, under a series of
// target counts including both extremes. Both channels idle at random, the
// result side holds off long enough to back up the input, and a monitor
// predicts and checks every result beat.
// ----------------------------------------------------------------------------
module testbench import dct_pkg::*; ();

    localparam int VALUE_BITS  = 20;
    localparam int VALUE_MAX   = (1 << VALUE_BITS) - 1;
    localparam int CYCLE_LIMIT = 12_000_000;
    localparam int LONG_HOLD   = 4000;
    localparam int TAIL_CYCLES = 64;
    localparam int PHASE_ITEMS = 10;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [TARGET_W-1:0] cfg_wr_data;

    int                  pending;
    int                  fail_count;
    int                  cycle_count = 0;

    // Handshake-side control; the sink and hold variables are shared with the result-ready process
    bit                  source_quiet = 1'b0;
    bit                  sink_quiet   = 1'b0;
    int unsigned         hold_token   = 0;
    int unsigned         hold_seen    = 0;
    int                  hold_left    = 0;
    int                  stall_left   = 0;

    logic [TARGET_W-1:0]   phase_targets [$] = '{8'd0, 8'd255, 8'd240, 8'd2, 8'd4, 8'd8};
    logic [VALUE_BITS-1:0] landmarks [$] = '{
        20'd0, 20'd1, 20'd2, 20'd3, 20'd4, 20'd12, 20'd36, 20'd180, 20'd5040,
        20'd65536, 20'd524288, 20'd720720, 20'd831600, 20'd1046529,
        20'd1048573, 20'd1048575, 20'h55555, 20'hAAAAA
    };

    dct_value_if #(.VALUE_BITS(VALUE_BITS)) value_ch ();
    dct_result_if                           result_ch ();

    divisor_count_trial_division_top #(.VALUE_BITS(VALUE_BITS)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (value_ch),
        .out_ch      (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    dct_count_monitor #(.VALUE_BITS(VALUE_BITS)) count_mon (
        .clk           (clk),
        .rst_n         (rst_n),
        .value_valid   (value_ch.valid),
        .value_ready   (value_ch.ready),
        .value         (value_ch.value),
        .result_valid  (result_ch.valid),
        .result_ready  (result_ch.ready),
        .divisor_count (result_ch.divisor_count),
        .count_matches (result_ch.count_matches),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap(input bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 20);
        else
            return $urandom_range(50, 300);
    endfunction

    // Values skew small since latency grows with sqrt(value)
    function automatic logic [VALUE_BITS-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return '0;
        else if (r < 5)
        begin
            case ($urandom_range(0, 2))
                0:       return 20'd720720;
                1:       return 20'd831600;
                default: return 20'd997920;
            endcase
        end
        else if (r < 15)
            return VALUE_BITS'($urandom_range(0, VALUE_MAX));
        else if (r < 30)
            return VALUE_BITS'($urandom_range(0, 65535));
        else
            return VALUE_BITS'($urandom_range(0, 4095));
    endfunction

    // One value beat, preceded by an idle gap; valid stays up for the next call
    task automatic offer_value(input logic [VALUE_BITS-1:0] v, input int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            value_ch.valid <= 1'b0;
            value_ch.value <= VALUE_BITS'($urandom_range(0, VALUE_MAX));
            repeat (gap) @(negedge clk);
        end
        value_ch.valid <= 1'b1;
        value_ch.value <= v;
        do
            @(posedge clk);
        while (!value_ch.ready);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_results();
        @(negedge clk);
        value_ch.valid <= 1'b0;
        value_ch.value <= VALUE_BITS'($urandom_range(0, VALUE_MAX));
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_target(input logic [TARGET_W-1:0] t);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= t;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Result-side ready: random stalls plus a long hold on request
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                stall_left = pick_gap(sink_quiet);
            end
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("divisor_count_trial_division_top regression: fail");
        $finish;
    end

    // Stimulus
    initial
    begin
        rst_n          = 1'b0;
        value_ch.valid = 1'b0;
        value_ch.value = '0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Landmarks under the reset target
        foreach (landmarks[i])
            offer_value(landmarks[i], pick_gap(source_quiet));

        // Random phases, one target each
        foreach (phase_targets[p])
        begin
            write_target(phase_targets[p]);
            source_quiet = (p % 3 == 1);
            sink_quiet   = (p % 3 == 2);
            if (phase_targets[p] == 8'd0)
                offer_value('0, 0);
            if (phase_targets[p] == 8'd240)
                offer_value(20'd720720, 0);
            repeat (PHASE_ITEMS)
                offer_value(pick_value(), pick_gap(source_quiet));
        end

        // Back-pressure: results held off while small values keep coming
        drain_results();
        source_quiet = 1'b1;
        sink_quiet   = 1'b0;
        hold_token++;
        repeat (8)
            offer_value(VALUE_BITS'($urandom_range(0, 255)), 0);

        // Last phase with a random target
        write_target(TARGET_W'($urandom_range(1, 254)));
        source_quiet = 1'b0;
        repeat (PHASE_ITEMS)
            offer_value(pick_value(), pick_gap(source_quiet));

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("divisor_count_trial_division_top regression: pass");
        else
            $display("divisor_count_trial_division_top regression: fail");
        $finish;
    end

endmodule

### files.f
sv/dct_pkg.sv
sv/dct_value_if.sv
sv/dct_result_if.sv
sv/dct_rem_unit.sv
sv/dct_datapath.sv
sv/dct_ctrl.sv
sv/divisor_count_trial_division_top.sv
sim/dct_count_monitor.sv
sim/testbench.sv
